// ----- sv/lkvc_pkg.sv -----
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W  = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CFG_W   = 5;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int CMP_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    localparam logic [CFG_W-1:0]        CFG_RESET   = CFG_W'(16);
    localparam logic                    KIND_LOOKUP = 1'b0;
    localparam logic                    KIND_STORE  = 1'b1;
    localparam logic signed [VAL_W-1:0] MISS_VALUE  = '1;

    typedef struct packed {
        logic                    kind;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic load;
        logic match;
        logic update;
    } t_dp_cmd;

    typedef struct packed {
        logic is_lookup;
    } t_dp_sts;

endpackage

// ----- sv/lru_key_value_cache.sv -----
// fully associative key/value cache with least-recently-used replacement
// input channel: i_in_valid / o_in_stall carry one item (kind, key, value)
//   kind lookup: returns one result item (found, read_value)
//   kind store: writes the table and returns nothing
// output channel: o_out_valid / i_out_stall carry the result item
// an item is taken when valid is high and stall is low
// one item is in flight at a time
//   store: after acceptance the item passes key compare and update, then the
//   next item can be taken
//   lookup: after key compare and update the result is valid until taken, and
//   the next item can be taken in the cycle after the result is taken
// the steps are set by the controller: capture, key compare, update
// a stalled result holds its value and keeps the input stalled
// i_cfg_wr_en writes entries_in_use (0 acts as 1, above the table size acts
//   as the table size); write only while no item is in flight
// reset (synchronous, active low) clears all valid bits and recency ranks,
//   sets entries_in_use to 16, stalls the input and idles the controller
module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lkvc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .o_out         (o_out),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

// ----- sv/lkvc_ctrl.sv -----
module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = i_sts.is_lookup ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_in_stall   = 1'b1;
        o_out_valid  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = !i_rst_n;
                o_cmd.load = i_in_valid;
            end
            ST_MATCH: begin
                o_cmd.match = 1'b1;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            ST_RESULT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- sv/lkvc_dp.sv -----
module lkvc_dp
    import lkvc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  t_in_item         i_in,
    output t_out_item        o_out,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts
);

    // captured item
    logic                    r_kind;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_value;

    // table
    logic signed [KEY_W-1:0] r_keys   [ENTRIES];
    logic signed [VAL_W-1:0] r_values [ENTRIES];
    logic [ENTRIES-1:0]      r_valid;
    logic [RANK_W-1:0]       r_rank   [ENTRIES];
    logic [RANK_W-1:0]       n_rank   [ENTRIES];
    logic [CNT_W-1:0]        r_count;
    logic [CFG_W-1:0]        r_cfg;

    // match stage results
    logic                    r_hit;
    logic [IDX_W-1:0]        r_hit_idx;
    logic [RANK_W-1:0]       r_hit_rank;
    logic [IDX_W-1:0]        r_slot;

    t_out_item               r_out;

    logic                    hit;
    logic [IDX_W-1:0]        hit_idx;
    logic [RANK_W-1:0]       hit_rank;
    logic [IDX_W-1:0]        victim;
    logic [IDX_W-1:0]        free_idx;
    logic [RANK_W-1:0]       last_rank;
    logic [CMP_W-1:0]        cfg_ext;
    logic [CMP_W-1:0]        cnt_ext;
    logic [CMP_W-1:0]        limit;
    logic                    evict;
    logic                    is_store;

    assign is_store  = (r_kind == KIND_STORE);
    assign last_rank = RANK_W'(r_count - CNT_W'(1));
    assign cfg_ext   = CMP_W'(r_cfg);
    assign cnt_ext   = CMP_W'(r_count);

    always_comb begin
        if (cfg_ext == '0) begin
            limit = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(ENTRIES)) begin
            limit = CMP_W'(ENTRIES);
        end else begin
            limit = cfg_ext;
        end
    end

    assign evict = (cnt_ext >= limit);

    // parallel key compare, victim and free slot search
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        hit_rank = '0;
        victim   = '0;
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_valid[i] && (r_keys[i] == r_key)) begin
                hit      = 1'b1;
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | r_rank[i];
            end
            if (r_valid[i] && (r_rank[i] == last_rank)) begin
                victim = victim | IDX_W'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // recency update
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (r_hit) begin
                if (IDX_W'(i) == r_hit_idx) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end else if (is_store) begin
                if (IDX_W'(i) == r_slot) begin
                    n_rank[i] = '0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in.kind;
            r_key   <= i_in.key;
            r_value <= i_in.value;
        end
        if (i_cmd.match) begin
            r_hit      <= hit;
            r_hit_idx  <= hit_idx;
            r_hit_rank <= hit_rank;
            r_slot     <= evict ? victim : free_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.update) begin
            if (r_hit || is_store) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
            if (is_store && !r_hit) begin
                r_valid[r_slot] <= 1'b1;
                if (!r_valid[r_slot]) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && is_store) begin
            if (r_hit) begin
                r_values[r_hit_idx] <= r_value;
            end else begin
                r_keys[r_slot]   <= r_key;
                r_values[r_slot] <= r_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !is_store) begin
            r_out.found      <= r_hit;
            r_out.read_value <= r_hit ? r_values[r_hit_idx] : MISS_VALUE;
        end
    end

    assign o_out           = r_out;
    assign o_sts.is_lookup = (r_kind == KIND_LOOKUP);

endmodule

// ----- tb/sv/tb_lru_key_value_cache.sv -----
module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 32;
    localparam int RAND_PER_PH = 112;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out;
    logic             i_cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] i_cfg_wr_data = '0;

    lru_key_value_cache DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in          (i_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out         (o_out),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // shadow copy of the table
    logic [KEY_W-1:0] shadow_key  [ENTRIES];
    logic [VAL_W-1:0] shadow_val  [ENTRIES];
    bit               shadow_vld  [ENTRIES];
    int unsigned      shadow_rank [ENTRIES];
    logic [CFG_W-1:0] shadow_limit = CFG_RESET;

    t_in_item                pending_ops[$];
    t_out_item               lookup_answers[$];
    logic signed [KEY_W-1:0] key_pool[POOL_SIZE];

    int unsigned ops_queued    = 0;
    int unsigned ops_taken     = 0;
    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int          send_gap_pct  = 0;
    int          recv_stall_pct = 0;
    bit          in_fire = 1'b0;
    t_out_item   want;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned effective_limit();
        int unsigned lim;
        lim = shadow_limit;
        if (lim == 0) begin
            lim = 1;
        end
        if (lim > ENTRIES) begin
            lim = ENTRIES;
        end
        return lim;
    endfunction

    function automatic void make_most_recent(int e);
        int unsigned r;
        r = shadow_rank[e];
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_vld[i] && i != e && shadow_rank[i] < r) begin
                shadow_rank[i]++;
            end
        end
        shadow_rank[e] = 0;
    endfunction

    function automatic void apply_to_shadow_cache(t_in_item it);
        int          hit;
        int          slot;
        int unsigned count;
        int unsigned worst;
        t_out_item   ans;
        hit = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && shadow_vld[i] && shadow_key[i] == it.key) begin
                hit = i;
            end
        end
        if (it.kind == KIND_LOOKUP) begin
            if (hit >= 0) begin
                ans.found      = 1'b1;
                ans.read_value = shadow_val[hit];
                make_most_recent(hit);
            end else begin
                ans.found      = 1'b0;
                ans.read_value = MISS_VALUE;
            end
            lookup_answers.push_back(ans);
            return;
        end
        if (hit >= 0) begin
            shadow_val[hit] = it.value;
            make_most_recent(hit);
            return;
        end
        count = 0;
        slot  = -1;
        worst = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_vld[i]) begin
                count++;
            end
        end
        if (count >= effective_limit()) begin
            // evict the least recent entry
            for (int i = 0; i < ENTRIES; i++) begin
                if (shadow_vld[i] && (slot < 0 || shadow_rank[i] >= worst)) begin
                    worst = shadow_rank[i];
                    slot  = i;
                end
            end
            if (slot >= 0) begin
                shadow_vld[slot] = 1'b0;
            end
        end else begin
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (!shadow_vld[i]) begin
                    slot = i;
                end
            end
        end
        if (slot < 0) begin
            return;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_vld[i]) begin
                shadow_rank[i]++;
            end
        end
        shadow_key[slot]  = it.key;
        shadow_val[slot]  = it.value;
        shadow_vld[slot]  = 1'b1;
        shadow_rank[slot] = 0;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic queue_op(logic kind, logic signed [KEY_W-1:0] key,
                            logic signed [VAL_W-1:0] value);
        t_in_item it;
        it.kind  = kind;
        it.key   = key;
        it.value = value;
        pending_ops.push_back(it);
        ops_queued++;
    endtask

    task automatic write_limit(logic [CFG_W-1:0] lim);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= lim;
        shadow_limit = lim;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (ops_taken != ops_queued || lookup_answers.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    // driver
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (!i_in_valid || in_fire) begin
            if (i_rst_n && pending_ops.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                i_in       <= pending_ops.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (lookup_answers.size() == 0) begin
                    report_mismatch($sformatf("unexpected result found=%0b value=%0d",
                                              o_out.found, o_out.read_value));
                end else begin
                    want = lookup_answers.pop_front();
                    if (o_out.found !== want.found) begin
                        report_mismatch($sformatf("found %0b, want %0b",
                                                  o_out.found, want.found));
                    end
                    if (o_out.read_value !== want.read_value) begin
                        report_mismatch($sformatf("read_value %0d, want %0d",
                                                  o_out.read_value, want.read_value));
                    end
                end
            end
            if (in_fire) begin
                apply_to_shadow_cache(i_in);
                ops_taken++;
            end
        end
    end

    initial begin
        logic [CFG_W-1:0]        limits[8];
        int                      span;
        logic                    kind;
        logic signed [KEY_W-1:0] key;

        for (int i = 0; i < ENTRIES; i++) begin
            shadow_key[i]  = '0;
            shadow_val[i]  = '0;
            shadow_vld[i]  = 1'b0;
            shadow_rank[i] = 0;
        end
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = -32'sd1;
        key_pool[3] = 32'sd0;
        for (int i = 4; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
        limits = '{5'd4, 5'd0, 5'd31, 5'd1, 5'd17, 5'd2, 5'd9, 5'd16};

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed items at the reset limit
        queue_op(KIND_LOOKUP, key_pool[3], '1);
        queue_op(KIND_STORE, key_pool[0], 32'sh7FFF_FFFF);
        queue_op(KIND_STORE, key_pool[1], 32'sh8000_0000);
        queue_op(KIND_STORE, key_pool[2], -32'sd1);
        queue_op(KIND_STORE, key_pool[3], 32'sd0);
        for (int i = 0; i < 4; i++) begin
            queue_op(KIND_LOOKUP, key_pool[i], 32'sd0);
        end
        queue_op(KIND_STORE, key_pool[1], 32'sd5);
        queue_op(KIND_LOOKUP, key_pool[1], 32'sd0);
        queue_op(KIND_LOOKUP, 32'sd1, 32'sd0);
        for (int i = 4; i < 17; i++) begin
            queue_op(KIND_STORE, key_pool[i], $urandom);
        end
        queue_op(KIND_LOOKUP, key_pool[0], 32'sd0);
        wait_for_drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_limit(limits[ph]);
            case (ph % 4)
                0: begin
                    send_gap_pct = 0;  recv_stall_pct = 0;
                end
                1: begin
                    send_gap_pct = 65; recv_stall_pct = 0;
                end
                2: begin
                    send_gap_pct = 0;  recv_stall_pct = 65;
                end
                default: begin
                    send_gap_pct = 11; recv_stall_pct = 11;
                end
            endcase
            span = effective_limit() + 3;
            if (span > POOL_SIZE - 1) begin
                span = POOL_SIZE - 1;
            end
            for (int n = 0; n < RAND_PER_PH; n++) begin
                kind = 1'($urandom_range(1));
                if ($urandom_range(9) < 8) begin
                    key = key_pool[5'($urandom_range(span))];
                end else begin
                    key = $urandom;
                end
                queue_op(kind, key, $urandom);
            end
            wait_for_drain();
        end

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/lkvc_pkg.sv
sv/lkvc_ctrl.sv
sv/lkvc_dp.sv
sv/lru_key_value_cache.sv
tb/sv/tb_lru_key_value_cache.sv
